>>> hdl/sclc_pkg.sv
`timescale 1ns / 1ps

package sclc_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned MEAS_W  = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CCT_HOLD   = 2'd0,
        REG_LUX_HOLD   = 2'd1,
        REG_BRIGHT_MIN = 2'd2
    } sclc_reg_t;

    localparam logic [HOLD_W-1:0]  CCT_HOLD_RESET   = 16'd200;
    localparam logic [HOLD_W-1:0]  LUX_HOLD_RESET   = 16'd300;
    localparam logic [LEVEL_W-1:0] BRIGHT_MIN_RESET = 8'd20;
    localparam logic [LEVEL_W-1:0] COLOUR_RESET     = 8'd127;
    localparam logic [LEVEL_W-1:0] BRIGHT_RESET     = 8'd200;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 8'd255;

    // Error thresholds and step sizes for the colour loop.
    localparam logic [MEAS_W-1:0] CCT_THR_BIG = 16'd1000;
    localparam logic [MEAS_W-1:0] CCT_THR_MID = 16'd500;
    localparam logic [MEAS_W-1:0] CCT_THR_LOW = 16'd200;
    localparam logic [3:0]        CCT_STEP_BIG = 4'd10;
    localparam logic [3:0]        CCT_STEP_MID = 4'd5;
    localparam logic [3:0]        CCT_STEP_LOW = 4'd2;

    // Error thresholds and step sizes for the brightness loop.
    localparam logic [MEAS_W-1:0] LUX_THR_BIG = 16'd200;
    localparam logic [MEAS_W-1:0] LUX_THR_MID = 16'd100;
    localparam logic [MEAS_W-1:0] LUX_THR_LOW = 16'd50;
    localparam logic [3:0]        LUX_STEP_BIG = 4'd10;
    localparam logic [3:0]        LUX_STEP_MID = 4'd5;
    localparam logic [3:0]        LUX_STEP_LOW = 4'd3;

    localparam logic [3:0]        STEP_MIN = 4'd1;

    typedef struct packed {
        logic [HOLD_W-1:0]  cct_hold;
        logic [HOLD_W-1:0]  lux_hold;
        logic [LEVEL_W-1:0] bright_min;
    } sclc_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [MEAS_W-1:0] measured_lux;
        logic [MEAS_W-1:0] target_lux;
        logic [MEAS_W-1:0] measured_cct;
        logic [MEAS_W-1:0] target_cct;
    } sclc_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] colour;
        logic [LEVEL_W-1:0] bright;
        logic [TIME_W-1:0]  colour_at;
        logic [TIME_W-1:0]  bright_at;
    } sclc_state_t;

    // Exact x / 255 for any product of two 8-bit levels (x up to 255 * 255): (x + (x >> 8) + 1) >> 8.
    function automatic logic [LEVEL_W-1:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

>>> hdl/sclc_level_update.sv
`timescale 1ns / 1ps

module sclc_level_update (
    input  sclc_pkg::sclc_cfg_t   cfg,
    input  sclc_pkg::sclc_item_t  item,
    input  sclc_pkg::sclc_state_t state,
    output sclc_pkg::sclc_state_t state_next
);
    import sclc_pkg::*;

    logic signed [MEAS_W:0]   cerr;
    logic signed [MEAS_W:0]   lerr;
    logic        [MEAS_W-1:0] cabs;
    logic        [MEAS_W-1:0] labs;
    logic        [3:0]        cstep;
    logic        [3:0]        lstep;
    logic        [TIME_W-1:0] cdelta;
    logic        [TIME_W-1:0] ldelta;
    logic                     chold_ok;
    logic                     lhold_ok;
    logic signed [9:0]        cmoved;
    logic signed [9:0]        lmoved;
    logic        [LEVEL_W-1:0] cclamp;
    logic        [LEVEL_W-1:0] lclamp;

    always_comb begin
        cerr = $signed({1'b0, item.target_cct}) - $signed({1'b0, item.measured_cct});
        lerr = $signed({1'b0, item.target_lux}) - $signed({1'b0, item.measured_lux});
        cabs = cerr[MEAS_W] ? MEAS_W'(-cerr) : cerr[MEAS_W-1:0];
        labs = lerr[MEAS_W] ? MEAS_W'(-lerr) : lerr[MEAS_W-1:0];

        if (cabs > CCT_THR_BIG) begin
            cstep = CCT_STEP_BIG;
        end else if (cabs > CCT_THR_MID) begin
            cstep = CCT_STEP_MID;
        end else if (cabs > CCT_THR_LOW) begin
            cstep = CCT_STEP_LOW;
        end else begin
            cstep = STEP_MIN;
        end

        if (labs > LUX_THR_BIG) begin
            lstep = LUX_STEP_BIG;
        end else if (labs > LUX_THR_MID) begin
            lstep = LUX_STEP_MID;
        end else if (labs > LUX_THR_LOW) begin
            lstep = LUX_STEP_LOW;
        end else begin
            lstep = STEP_MIN;
        end

        // Wrapping difference, so time running backwards counts as elapsed.
        cdelta   = item.now_ms - state.colour_at;
        ldelta   = item.now_ms - state.bright_at;
        chold_ok = cdelta >= {{(TIME_W-HOLD_W){1'b0}}, cfg.cct_hold};
        lhold_ok = ldelta >= {{(TIME_W-HOLD_W){1'b0}}, cfg.lux_hold};

        cmoved = $signed({2'b00, state.colour});
        if (cerr > 0) begin
            cmoved = cmoved + $signed({6'd0, cstep});
        end else if (cerr < 0) begin
            cmoved = cmoved - $signed({6'd0, cstep});
        end
        lmoved = $signed({2'b00, state.bright});
        if (lerr > 0) begin
            lmoved = lmoved + $signed({6'd0, lstep});
        end else if (lerr < 0) begin
            lmoved = lmoved - $signed({6'd0, lstep});
        end

        if (cmoved < 0) begin
            cclamp = '0;
        end else if (cmoved > $signed({2'b00, LEVEL_MAX})) begin
            cclamp = LEVEL_MAX;
        end else begin
            cclamp = cmoved[LEVEL_W-1:0];
        end

        // The floor check comes first; a floor above the level lifts it.
        if (lmoved < $signed({2'b00, cfg.bright_min})) begin
            lclamp = cfg.bright_min;
        end else if (lmoved > $signed({2'b00, LEVEL_MAX})) begin
            lclamp = LEVEL_MAX;
        end else begin
            lclamp = lmoved[LEVEL_W-1:0];
        end

        state_next = state;
        if (chold_ok && (cclamp != state.colour)) begin
            state_next.colour    = cclamp;
            state_next.colour_at = item.now_ms;
        end
        if (lhold_ok && (lclamp != state.bright)) begin
            state_next.bright    = lclamp;
            state_next.bright_at = item.now_ms;
        end
    end

endmodule

>>> hdl/stepped_cct_lux_controller.sv
`timescale 1ns / 1ps

// Stepped colour and brightness controller. Each input beat carries target and
// measured colour temperature and light level plus a millisecond timestamp, and
// produces exactly one output beat with the warm and cool PWM duties and the two
// levels after the update. One beat is accepted every clock cycle unless m_tready
// back-pressure has filled the pipeline. Each accepted input is loaded into the
// input register, the level update is then written into the state registers, and
// the duties are then loaded into the output register; a stall holds each stage.
// The one-cycle issue rate is set by the level update loop, which reads the
// colour and brightness state and writes its update back in the same cycle.
// Configuration writes are accepted at any time but must only be issued while
// no beats are in flight; cfg_ready is always high.
module stepped_cct_lux_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg_data: cct_hold_ms or lux_hold_ms [15:0], brightness_floor [7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: target_cct [15:0], measured_cct [31:16], target_lux [47:32],
    //          measured_lux [63:48], now_ms [95:64]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: warm_duty [7:0], cool_duty [15:8], colour_level [23:16],
    //          brightness_level [31:24]
    output logic [31:0] m_tdata
);
    import sclc_pkg::*;

    sclc_cfg_t   cfg_reg;
    sclc_item_t  item_reg;
    sclc_state_t state_reg;
    sclc_state_t state_next;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic [31:0] out_reg;
    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic [15:0] warm_prod;
    logic [15:0] cool_prod;
    logic [7:0]  warm_duty;
    logic [7:0]  cool_duty;

    assign cfg_ready = 1'b1;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

    sclc_level_update u_level (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next)
    );

    // Stage two has no payload of its own: the state only moves when a beat
    // enters stage two, so while stage two holds a beat the state registers
    // carry exactly that beat's levels.
    always_comb begin
        warm_prod = {8'd0, LEVEL_MAX - state_reg.colour} * {8'd0, state_reg.bright};
        cool_prod = {8'd0, state_reg.colour} * {8'd0, state_reg.bright};
        warm_duty = div255(warm_prod);
        cool_duty = div255(cool_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cct_hold   <= CCT_HOLD_RESET;
            cfg_reg.lux_hold   <= LUX_HOLD_RESET;
            cfg_reg.bright_min <= BRIGHT_MIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_CCT_HOLD:   cfg_reg.cct_hold   <= cfg_data;
                REG_LUX_HOLD:   cfg_reg.lux_hold   <= cfg_data;
                REG_BRIGHT_MIN: cfg_reg.bright_min <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg              <= 1'b0;
            v2_reg              <= 1'b0;
            v3_reg              <= 1'b0;
            state_reg.colour    <= COLOUR_RESET;
            state_reg.bright    <= BRIGHT_RESET;
            state_reg.colour_at <= '0;
            state_reg.bright_at <= '0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
                if (v1_reg) begin
                    state_reg <= state_next;
                end
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && adv1) begin
            item_reg <= s_tdata;
        end
        if (v2_reg && adv3) begin
            out_reg <= {state_reg.bright, state_reg.colour, cool_duty, warm_duty};
        end
    end

endmodule
